// File: hw/rtl/csaf_pkg.sv
// Shared types and constants of the cross stencil average filter.
// Used by the top level; has no dependencies of its own.
package csaf_pkg;

	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [PIX_W-1:0]      pixel_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef struct packed {
		logic   last;
		pixel_t pix;
	} out_item_t;

	// Kind of an input item.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// Register indexes of the configuration port.
	localparam cfg_idx_t CFG_RADIUS = 2'd0;
	localparam cfg_idx_t CFG_WIDTH  = 2'd1;
	localparam cfg_idx_t CFG_HEIGHT = 2'd2;

	localparam logic [3:0] RADIUS_RST = 4'd3;
	localparam cfg_data_t  WIDTH_RST  = 12'd640;
	localparam cfg_data_t  HEIGHT_RST = 12'd480;

endpackage

// File: hw/rtl/csaf_ram.sv
// Generic simple dual port RAM: one write port, two read ports, registered reads.
// No dependencies. Contents are undefined until written.
module csaf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Reads return the old contents when the same entry is written in that cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: hw/rtl/cross_stencil_average_filter.sv
// Cross stencil average filter: top level with counters, row bank RAMs and output queue.
// Depends on csaf_pkg and csaf_ram.
// Throughput: one item per clock while the output queue keeps s_tready high. Each ring row
// is its own RAM bank with one write and two read ports, so a pixel write and the four
// neighbor reads all happen in the same cycle. A result passes stage 1 and the output queue.
// Reset: counters and queue are cleared and registers take their defaults at once; the row
// banks are not cleared.
module cross_stencil_average_filter #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int MAX_RADIUS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  csaf_pkg::pixel_t    s_tdata,   // [7:0] chan0_in, [15:8] chan1_in, [23:16] chan2_in
	input  logic                s_tuser,   // [0] req_type
	output logic                m_tvalid,
	input  logic                m_tready,
	output csaf_pkg::pixel_t    m_tdata,   // [7:0] chan0_out, [15:8] chan1_out, [23:16] chan2_out
	output logic                m_tlast,
	input  logic                cfg_we,
	input  csaf_pkg::cfg_idx_t  cfg_index,
	input  csaf_pkg::cfg_data_t cfg_data
);
	import csaf_pkg::*;

	localparam int RING   = 2 * MAX_RADIUS + 1;
	localparam int BANK_W = $clog2(RING);
	localparam int BW1    = BANK_W + 1;
	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int COL_W  = $clog2(MAX_WIDTH + 2);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
	localparam int MX_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int SUM_W  = ((MX_W > RAD_W) ? MX_W : RAD_W) + 2;

	typedef logic [BANK_W-1:0] bank_t;

	function automatic bank_t bank_next(input bank_t b);
		return (b == BANK_W'(RING - 1)) ? '0 : b + BANK_W'(1);
	endfunction

	// Configuration registers.
	logic [3:0] radius_q;
	cfg_data_t  width_q;
	cfg_data_t  height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data[3:0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [RAD_W-1:0] r_eff;
	logic [COL_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	bank_t            r_bank;

	assign r_eff  = (32'(radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_q);
	assign w_eff  = (width_q == '0) ? COL_W'(1) :
			(32'(width_q) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : COL_W'(width_q);
	assign h_eff  = (height_q == '0) ? ROW_W'(1) :
			(32'(height_q) > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT) : ROW_W'(height_q);
	assign r_bank = BANK_W'(r_eff);

	// Position counters; the bank index follows the row modulo the ring size.
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	bank_t            in_bank_q, out_bank_q;

	logic [ROW_W-1:0] in_row_a, in_row_b, out_row_a, in_row_n, out_row_n;
	logic [COL_W-1:0] in_col_a, in_col_b, out_col_a, in_col_n, out_col_n;
	bank_t            in_bank_a, in_bank_b, out_bank_a, in_bank_n, out_bank_n;
	logic [SUM_W-1:0] need_row;
	logic             s_acc, wr_en, ready, emit, filt, is_last;

	logic              v_s1;
	logic [FIFO_CNT_W-1:0] count_q;

	assign s_acc = s_tvalid && s_tready;

	always_comb begin
		// Counters past the frame after a register change wrap or drop the frame.
		in_row_a  = in_row_q;
		in_col_a  = in_col_q;
		in_bank_a = in_bank_q;
		if (in_col_q >= w_eff) begin
			in_col_a  = '0;
			in_row_a  = in_row_q + ROW_W'(1);
			in_bank_a = bank_next(in_bank_q);
		end
		out_row_a  = out_row_q;
		out_col_a  = out_col_q;
		out_bank_a = out_bank_q;
		if (out_col_q >= w_eff) begin
			out_col_a  = '0;
			out_row_a  = out_row_q + ROW_W'(1);
			out_bank_a = bank_next(out_bank_q);
		end
		if (out_row_a >= h_eff) begin
			in_row_a   = '0;
			in_col_a   = '0;
			in_bank_a  = '0;
			out_row_a  = '0;
			out_col_a  = '0;
			out_bank_a = '0;
		end

		wr_en     = s_acc && (s_tuser == REQ_PIXEL) && (in_row_a < h_eff);
		in_row_b  = in_row_a;
		in_col_b  = in_col_a;
		in_bank_b = in_bank_a;
		if (wr_en) begin
			in_col_b = in_col_a + COL_W'(1);
			if (in_col_b >= w_eff) begin
				in_col_b  = '0;
				in_row_b  = in_row_a + ROW_W'(1);
				in_bank_b = bank_next(in_bank_a);
			end
		end

		// The source of the next output is in once the input position has passed it.
		need_row = SUM_W'(out_row_a) + SUM_W'(r_eff);
		ready    = (in_row_b >= h_eff) || (SUM_W'(in_row_b) > need_row) ||
			   ((SUM_W'(in_row_b) == need_row) && (in_col_b > out_col_a));
		emit     = s_acc && ready;

		filt    = (SUM_W'(out_row_a) >= SUM_W'(r_eff) + SUM_W'(1)) &&
			  (need_row + SUM_W'(1) <= SUM_W'(h_eff)) &&
			  (SUM_W'(out_col_a) >= SUM_W'(r_eff) + SUM_W'(1)) &&
			  (SUM_W'(out_col_a) + SUM_W'(r_eff) + SUM_W'(2) <= SUM_W'(w_eff));
		is_last = (SUM_W'(out_row_a) + SUM_W'(1) == SUM_W'(h_eff)) &&
			  (SUM_W'(out_col_a) + SUM_W'(1) == SUM_W'(w_eff));

		in_row_n   = in_row_b;
		in_col_n   = in_col_b;
		in_bank_n  = in_bank_b;
		out_row_n  = out_row_a;
		out_col_n  = out_col_a;
		out_bank_n = out_bank_a;
		if (emit) begin
			if (is_last) begin
				in_row_n   = '0;
				in_col_n   = '0;
				in_bank_n  = '0;
				out_row_n  = '0;
				out_col_n  = '0;
				out_bank_n = '0;
			end else begin
				out_col_n = out_col_a + COL_W'(1);
				if (out_col_n >= w_eff) begin
					out_col_n  = '0;
					out_row_n  = out_row_a + ROW_W'(1);
					out_bank_n = bank_next(out_bank_a);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_bank_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_bank_q <= '0;
		end else if (s_acc) begin
			in_row_q   <= in_row_n;
			in_col_q   <= in_col_n;
			in_bank_q  <= in_bank_n;
			out_row_q  <= out_row_n;
			out_col_q  <= out_col_n;
			out_bank_q <= out_bank_n;
		end
	end

	// Read addresses: the center row bank serves left (or center) and right; the
	// rows above and below come from their own banks.
	logic [AW-1:0] wr_col, addr_j, addr_l, addr_r, addr_c;
	bank_t         bank_up, bank_dn;
	logic [BW1-1:0] dn_sum;
	logic          hit_up, hit_dn, hit_a, hit_b;

	assign wr_col = in_col_a[AW-1:0];
	assign addr_j = out_col_a[AW-1:0];
	assign addr_l = AW'(SUM_W'(out_col_a) - SUM_W'(r_eff));
	assign addr_r = AW'(SUM_W'(out_col_a) + SUM_W'(r_eff));
	assign addr_c = filt ? addr_l : addr_j;

	assign bank_up = (out_bank_a >= r_bank) ? out_bank_a - r_bank :
			 BANK_W'(BW1'(out_bank_a) + BW1'(RING) - BW1'(r_bank));
	assign dn_sum  = BW1'(out_bank_a) + BW1'(r_bank);
	assign bank_dn = (dn_sum >= BW1'(RING)) ? BANK_W'(dn_sum - BW1'(RING)) : BANK_W'(dn_sum);

	// A read of the entry written in the same cycle takes the incoming pixel.
	assign hit_up = wr_en && (in_bank_a == bank_up) && (wr_col == addr_j);
	assign hit_dn = wr_en && (in_bank_a == bank_dn) && (wr_col == addr_j);
	assign hit_a  = wr_en && (in_bank_a == out_bank_a) && (wr_col == addr_c);
	assign hit_b  = wr_en && (in_bank_a == out_bank_a) && (wr_col == addr_r);

	pixel_t rd_a [RING];
	pixel_t rd_b [RING];

	for (genvar b = 0; b < RING; b++) begin : g_bank
		csaf_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk     (clk),
			.we      (wr_en && (in_bank_a == BANK_W'(b))),
			.waddr   (wr_col),
			.wdata   (s_tdata),
			.raddr_a ((out_bank_a == BANK_W'(b)) ? addr_c : addr_j),
			.raddr_b (addr_r),
			.rdata_a (rd_a[b]),
			.rdata_b (rd_b[b])
		);
	end

	// Stage 1: read data arrives; average or pass through.
	logic   filt_s1, last_s1, hit_up_s1, hit_dn_s1, hit_a_s1, hit_b_s1;
	bank_t  bank_up_s1, bank_dn_s1, bank_c_s1;
	pixel_t wpix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		filt_s1    <= filt;
		last_s1    <= is_last;
		hit_up_s1  <= hit_up;
		hit_dn_s1  <= hit_dn;
		hit_a_s1   <= hit_a;
		hit_b_s1   <= hit_b;
		bank_up_s1 <= bank_up;
		bank_dn_s1 <= bank_dn;
		bank_c_s1  <= out_bank_a;
		wpix_s1    <= s_tdata;
	end

	pixel_t px_up, px_dn, px_l, px_r, avg_pix, res_pix;

	assign px_up = hit_up_s1 ? wpix_s1 : rd_a[bank_up_s1];
	assign px_dn = hit_dn_s1 ? wpix_s1 : rd_a[bank_dn_s1];
	assign px_l  = hit_a_s1  ? wpix_s1 : rd_a[bank_c_s1];
	assign px_r  = hit_b_s1  ? wpix_s1 : rd_b[bank_c_s1];

	always_comb begin
		logic [CH_W+1:0] acc;
		for (int c = 0; c < 3; c++) begin
			acc = {2'b00, px_up[c*CH_W +: CH_W]} + {2'b00, px_dn[c*CH_W +: CH_W]} +
			      {2'b00, px_l[c*CH_W +: CH_W]} + {2'b00, px_r[c*CH_W +: CH_W]};
			avg_pix[c*CH_W +: CH_W] = acc[CH_W+1:2];
		end
	end

	assign res_pix = filt_s1 ? avg_pix : px_l;

	// Output queue; input is held off while it could not take every result in flight.
	out_item_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic                  pop;
	out_item_t             head;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != '0);
	assign head     = fifo_q[rd_ptr_q];
	assign m_tdata  = head.pix;
	assign m_tlast  = head.last;
	assign s_tready = (count_q + FIFO_CNT_W'(v_s1)) < FIFO_CNT_W'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fifo_q[wr_ptr_q] <= '{last: last_s1, pix: res_pix};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (v_s1) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(v_s1) - FIFO_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((count_q < FIFO_CNT_W'(FIFO_DEPTH)) || pop))
		else $error("output queue written while full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("output queue count out of range");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_last) |=> ((in_row_q == '0) && (out_row_q == '0) && (out_col_q == '0)))
		else $error("counters not cleared after final pixel");

	a_banks_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && filt && (r_eff != '0)) |-> ((bank_up != out_bank_a) && (bank_dn != out_bank_a)))
		else $error("stencil rows share a bank");

endmodule
